FILE: hdl/ocpt_pkg.sv
// Shared types and constants for the occupancy prefix count table.
// Used by ocpt_ram and occupancy_prefix_count_table_core; no dependencies.
package ocpt_pkg;

    localparam int ENTRY_W     = 13;   // width of one table entry
    localparam int COORD_W     = 6;    // width of a coordinate field on the stream
    localparam int CFG_W       = 7;    // width of the size registers
    localparam int DIM_W       = 11;   // holds any size up to 1024
    localparam int CFG_IDX_W   = 1;    // width of the register index

    localparam int MAX_COLUMNS_DEF = 64;
    localparam int MAX_ROWS_DEF    = 64;

    localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_MOVE = 2'd1,
        OP_READ = 2'd2
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_LOAD = 5'b00100,
        S_MOVE = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

endpackage

FILE: hdl/ocpt_ram.sv
// Simple dual-port table memory: one write port, one read port, registered read data.
// Depends on ocpt_pkg for the entry width.
module ocpt_ram
    import ocpt_pkg::*;
#(
    parameter int DEPTH = MAX_COLUMNS_DEF * MAX_ROWS_DEF,
    parameter int AW    = 12
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic [ENTRY_W-1:0] i_wdata,
    input  logic [AW-1:0]      i_raddr,
    output logic [ENTRY_W-1:0] o_rdata
);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/occupancy_prefix_count_table_core.sv
// Top level of the occupancy prefix count table: sequencer, size registers, output register.
// Depends on ocpt_pkg and ocpt_ram.
//
// The block keeps a two-dimensional prefix count of occupied grid sites in one table memory.
// Items enter on the s_axis channel: tuser carries the op (load, move, read) and tdata the
// coordinates and the occupancy bit. Each item yields exactly one beat on the m_axis channel,
// with the count in tdata and the error flag in tuser. Size registers are written through the
// cfg channel, which is always ready, and should only be written while the block is idle.
// A rejected item goes straight to the done state; a read returns the registered table
// data at its site; a load makes three neighbor reads through the single read port, then
// one write of the built entry through the write port; and a move sweeps every entry
// in use in a read-modify-write pipeline at one entry per cycle. One item is worked on at a
// time; s_axis tready is high whenever the sequencer is idle, so the next item is taken right
// after a result reaches the output register, even while that beat still waits. If the
// receiver stalls, the finished result waits in the sequencer until the output register frees.
// Reset returns the size registers to 64 by 64 and empties the channels; the table contents
// are not cleared, and an entry must be loaded before it is read.
module occupancy_prefix_count_table_core
    import ocpt_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // cfg write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // item stream in
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // tdata: [5:0] site_x, [11:6] site_y, [17:12] dest_x, [23:18] dest_y, [24] occupied
    input  logic [31:0]          i_s_axis_tdata,
    // tuser: [1:0] op
    input  logic [1:0]           i_s_axis_tuser,
    // result stream out
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // tdata: [12:0] count
    output logic [15:0]          o_m_axis_tdata,
    // tuser: [0] error
    output logic [0:0]           o_m_axis_tuser
);

    localparam int XW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int YW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WIDEW = 2 * DIM_W;

    // Table index of site (x, y) is x * MAX_ROWS + y.
    function automatic logic [AW-1:0] f_addr(input logic [XW-1:0] x, input logic [YW-1:0] y);
        logic [WIDEW-1:0] a;
        a = WIDEW'(x) * WIDEW'(MAX_ROWS) + WIDEW'(y);
        return a[AW-1:0];
    endfunction

    // Stream fields.
    logic [COORD_W-1:0] in_sx, in_sy, in_dx, in_dy;
    logic               in_occ;
    t_op                in_op;

    // Size in use, limited by the table's physical size.
    logic [DIM_W-1:0]   cols_use, rows_use;
    logic               src_ok, dst_ok, same_site;

    // Registers and their next values.
    logic [CFG_W-1:0]   r_cols, n_cols, r_rows, n_rows;
    t_state             r_state, n_state;
    logic [XW-1:0]      r_sx, n_sx, r_dx, n_dx, r_ci, n_ci;
    logic [YW-1:0]      r_sy, n_sy, r_dy, n_dy, r_cj, n_cj;
    logic               r_occ, n_occ;
    logic [1:0]         r_step, n_step;
    logic [ENTRY_W-1:0] r_acc, n_acc;
    logic               r_swept, n_swept;
    logic               r_pv, n_pv, r_pinc, n_pinc, r_pdec, n_pdec;
    logic [AW-1:0]      r_paddr, n_paddr;
    logic [ENTRY_W-1:0] r_res_count, n_res_count;
    logic               r_res_err, n_res_err;
    logic               r_out_valid, n_out_valid;
    logic [ENTRY_W-1:0] r_out_count, n_out_count;
    logic               r_out_err, n_out_err;

    // Table ports.
    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

    // Neighbor coordinates, clamped to the site itself at the grid edge (value is masked).
    logic [XW-1:0]      left_x;
    logic [YW-1:0]      lower_y;
    logic               in_from, in_to, last_cell;
    logic [ENTRY_W-1:0] load_value;

    assign in_sx  = i_s_axis_tdata[5:0];
    assign in_sy  = i_s_axis_tdata[11:6];
    assign in_dx  = i_s_axis_tdata[17:12];
    assign in_dy  = i_s_axis_tdata[23:18];
    assign in_occ = i_s_axis_tdata[24];
    assign in_op  = t_op'(i_s_axis_tuser);

    assign cols_use = (DIM_W'(r_cols) < DIM_W'(MAX_COLUMNS)) ? DIM_W'(r_cols)
                                                               : DIM_W'(MAX_COLUMNS);
    assign rows_use = (DIM_W'(r_rows) < DIM_W'(MAX_ROWS)) ? DIM_W'(r_rows)
                                                            : DIM_W'(MAX_ROWS);

    assign src_ok    = (DIM_W'(in_sx) < cols_use) && (DIM_W'(in_sy) < rows_use);
    assign dst_ok    = (DIM_W'(in_dx) < cols_use) && (DIM_W'(in_dy) < rows_use);
    assign same_site = (in_sx == in_dx) && (in_sy == in_dy);

    assign left_x  = (r_sx == '0) ? r_sx : r_sx - XW'(1);
    assign lower_y = (r_sy == '0) ? r_sy : r_sy - YW'(1);

    // A cell changes when exactly one of the two quadrants holds it.
    assign in_from   = (r_ci >= r_sx) && (r_cj >= r_sy);
    assign in_to     = (r_ci >= r_dx) && (r_cj >= r_dy);
    assign last_cell = (DIM_W'(r_ci) == cols_use - DIM_W'(1))
                    && (DIM_W'(r_cj) == rows_use - DIM_W'(1));

    // Last step of a load: left + lower + occupied were gathered, the diagonal comes now.
    assign load_value = r_acc - (((r_sx != '0) && (r_sy != '0)) ? ram_rdata : '0);

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(16 - ENTRY_W)'(0), r_out_count};
    assign o_m_axis_tuser  = r_out_err;

    // Read address of the table.
    always_comb begin
        unique case (r_state)
            S_LOAD: begin
                unique case (r_step)
                    2'd0:    ram_raddr = f_addr(left_x, r_sy);
                    2'd1:    ram_raddr = f_addr(r_sx, lower_y);
                    default: ram_raddr = f_addr(left_x, lower_y);
                endcase
            end
            S_MOVE:  ram_raddr = f_addr(r_ci, r_cj);
            default: ram_raddr = f_addr(r_sx, r_sy);
        endcase
    end

    // Write port: the built entry at the end of a load, or the pending move update.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_paddr;
        ram_wdata = ram_rdata + (r_pinc ? ENTRY_W'(1) : {ENTRY_W{1'b1}});
        if ((r_state == S_LOAD) && (r_step == 2'd3)) begin
            ram_we    = 1'b1;
            ram_waddr = f_addr(r_sx, r_sy);
            ram_wdata = load_value;
        end else if ((r_state == S_MOVE) && r_pv && (r_pinc || r_pdec)) begin
            ram_we = 1'b1;
        end
    end

    // Sequencer.
    always_comb begin
        n_cols      = r_cols;
        n_rows      = r_rows;
        n_state     = r_state;
        n_sx        = r_sx;
        n_sy        = r_sy;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_occ       = r_occ;
        n_step      = r_step;
        n_acc       = r_acc;
        n_ci        = r_ci;
        n_cj        = r_cj;
        n_swept     = r_swept;
        n_pv        = r_pv;
        n_paddr     = r_paddr;
        n_pinc      = r_pinc;
        n_pdec      = r_pdec;
        n_res_count = r_res_count;
        n_res_err   = r_res_err;
        n_out_valid = r_out_valid;
        n_out_count = r_out_count;
        n_out_err   = r_out_err;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GRID_COLUMNS: n_cols = i_cfg_data;
                CFG_GRID_ROWS:    n_rows = i_cfg_data;
            endcase
        end

        // The output beat leaves on its handshake; a new result may replace it below.
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_sx        = XW'(in_sx);
                    n_sy        = YW'(in_sy);
                    n_dx        = XW'(in_dx);
                    n_dy        = YW'(in_dy);
                    n_occ       = in_occ;
                    n_step      = 2'd0;
                    n_ci        = '0;
                    n_cj        = '0;
                    n_swept     = 1'b0;
                    n_pv        = 1'b0;
                    n_res_count = '0;
                    n_res_err   = 1'b1;
                    n_state     = S_DONE;
                    unique case (in_op)
                        OP_LOAD: begin
                            if (src_ok) begin
                                n_res_err = 1'b0;
                                n_state   = S_LOAD;
                            end
                        end
                        OP_MOVE: begin
                            if (src_ok && dst_ok && !same_site) begin
                                n_res_err = 1'b0;
                                n_state   = S_MOVE;
                            end
                        end
                        OP_READ: begin
                            if (src_ok) begin
                                n_res_err = 1'b0;
                                n_state   = S_READ;
                            end
                        end
                        default: begin
                            n_res_err = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                if (r_step == 2'd0) begin
                    n_step = 2'd1;
                end else begin
                    n_res_count = ram_rdata;
                    n_state     = S_DONE;
                end
            end
            S_LOAD: begin
                n_step = r_step + 2'd1;
                unique case (r_step)
                    2'd0: ;
                    2'd1: n_acc = ENTRY_W'(r_occ) + ((r_sx != '0) ? ram_rdata : '0);
                    2'd2: n_acc = r_acc + ((r_sy != '0) ? ram_rdata : '0);
                    default: begin
                        n_res_count = load_value;
                        n_state     = S_DONE;
                    end
                endcase
            end
            S_MOVE: begin
                // Issue one read per cycle; the write of the previous cell lands alongside.
                if (!r_swept) begin
                    n_pv    = 1'b1;
                    n_paddr = f_addr(r_ci, r_cj);
                    n_pinc  = in_to && !in_from;
                    n_pdec  = in_from && !in_to;
                    if (last_cell) begin
                        n_swept = 1'b1;
                    end else if (DIM_W'(r_cj) == rows_use - DIM_W'(1)) begin
                        n_cj = '0;
                        n_ci = r_ci + XW'(1);
                    end else begin
                        n_cj = r_cj + YW'(1);
                    end
                end else begin
                    n_pv    = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_count = r_res_count;
                    n_out_err   = r_res_err;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols      <= SIZE_RESET;
            r_rows      <= SIZE_RESET;
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pv        <= 1'b0;
            r_swept     <= 1'b0;
            r_step      <= 2'd0;
        end else begin
            r_cols      <= n_cols;
            r_rows      <= n_rows;
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pv        <= n_pv;
            r_swept     <= n_swept;
            r_step      <= n_step;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        r_sx        <= n_sx;
        r_sy        <= n_sy;
        r_dx        <= n_dx;
        r_dy        <= n_dy;
        r_occ       <= n_occ;
        r_acc       <= n_acc;
        r_ci        <= n_ci;
        r_cj        <= n_cj;
        r_paddr     <= n_paddr;
        r_pinc      <= n_pinc;
        r_pdec      <= n_pdec;
        r_res_count <= n_res_count;
        r_res_err   <= n_res_err;
        r_out_count <= n_out_count;
        r_out_err   <= n_out_err;
    end

    ocpt_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule
